@@ sv/bsct_pkg.sv @@
// Shared types, constants and helpers for the button sequence configuration toggle.
package bsct_pkg;

  localparam int unsigned TimerW  = 16;
  localparam int unsigned ElapsW  = 8;
  localparam int unsigned ClicksW = 5;
  localparam int unsigned ExpW    = 4;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [TimerW-1:0]  TimerMax       = '1;
  localparam logic [TimerW-1:0]  TimeoutReset   = 16'd20000;
  localparam logic [ExpW-1:0]    ExpClicksReset = 4'd6;
  localparam logic               InitEnReset    = 1'b1;
  localparam logic [ClicksW-1:0] ClicksMax      = '1;

  // signal levels
  localparam logic [LevelW-1:0] LvlOff = 2'd0;
  localparam logic [LevelW-1:0] LvlOn  = 2'd1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTimeout   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExpClicks = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInitEn    = 2'd2;

  // mode codes as seen on the result
  localparam logic [1:0] ModeOffIdle = 2'd0;
  localparam logic [1:0] ModeCount   = 2'd1;
  localparam logic [1:0] ModeOnIdle  = 2'd2;
  localparam logic [1:0] ModeToggle  = 2'd3;

  typedef enum logic [3:0] {
    ST_OFF_IDLE = 4'b0001,
    ST_COUNT    = 4'b0010,
    ST_ON_IDLE  = 4'b0100,
    ST_TOGGLE   = 4'b1000
  } state_e;

  typedef struct packed {
    state_e              state;
    logic [ClicksW-1:0]  clicks;
    logic [LevelW-1:0]   last_btn;
    logic [TimerW-1:0]   timer;
    logic                enabled;
  } ctx_t;

  typedef struct packed {
    logic [TimerW-1:0] timeout_ms;
    logic [ExpW-1:0]   exp_clicks;
  } cfg_t;

  function automatic logic [1:0] mode_code(state_e st);
    logic [1:0] code;
    case (st)
      ST_OFF_IDLE: code = ModeOffIdle;
      ST_COUNT:    code = ModeCount;
      ST_ON_IDLE:  code = ModeOnIdle;
      ST_TOGGLE:   code = ModeToggle;
      default:     code = ModeOffIdle;
    endcase
    return code;
  endfunction

endpackage

@@ sv/button_sequence_config_toggle.sv @@
// Button sequence configuration toggle: poll stream in, status stream out.
// An input transfer's result is registered and appears on the output register in the next cycle.
// Throughput: one poll per cycle while the output is not stalled; the state and result registers update together.
// An input is taken while the result register is empty or being drained.
// Reset (async, active low): off-idle mode, counters and timer cleared, configuration
// at default values, enabled flag at the initial_enabled default, output empty.
module button_sequence_config_toggle
  import bsct_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [1:0] ignition_level, [3:2] button_level, [11:4] elapsed_ms, [15:12] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] enabled, [1] toggled, [3:2] mode, [8:4] clicks, [15:9] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i
);

  cfg_t cfg;
  ctx_t ctx_q, ctx_d, ctx_step;
  logic toggled;
  logic in_xfer, cfg_xfer;
  logic out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  assign cfg_ready_o     = 1'b1;
  assign cfg_xfer        = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;

  bsct_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_xfer),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  bsct_step u_step (
    .ctx_i     (ctx_q),
    .cfg_i     (cfg),
    .ign_i     (s_axis_tdata_i[1:0]),
    .btn_i     (s_axis_tdata_i[3:2]),
    .elapsed_i (s_axis_tdata_i[11:4]),
    .ctx_o     (ctx_step),
    .toggled_o (toggled)
  );

  always_comb begin
    ctx_d = in_xfer ? ctx_step : ctx_q;
    // stored setting reload on an initial_enabled write
    if (cfg_xfer && cfg_index_i == CfgInitEn) begin
      ctx_d.enabled = cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.state    <= ST_OFF_IDLE;
      ctx_q.clicks   <= '0;
      ctx_q.last_btn <= '0;
      ctx_q.timer    <= '0;
      ctx_q.enabled  <= InitEnReset;
    end else begin
      ctx_q <= ctx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= {7'd0, ctx_step.clicks, mode_code(ctx_step.state), toggled,
                     ctx_step.enabled};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

@@ sv/bsct_cfg_regs.sv @@
// Configuration register file for the button sequence toggle.
module bsct_cfg_regs
  import bsct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_idx_i,
  input  logic [CfgDatW-1:0] wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ms <= TimeoutReset;
      cfg_q.exp_clicks <= ExpClicksReset;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        CfgTimeout:   cfg_q.timeout_ms <= wr_data_i[TimerW-1:0];
        CfgExpClicks: cfg_q.exp_clicks <= wr_data_i[ExpW-1:0];
        CfgInitEn:    ; // only reloads the enabled flag, held in the top level
        default:      ; // unused index: write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/bsct_step.sv @@
// Per-poll next-state logic: timer update and the mode machine.
module bsct_step
  import bsct_pkg::*;
(
  input  ctx_t              ctx_i,
  input  cfg_t              cfg_i,
  input  logic [LevelW-1:0] ign_i,
  input  logic [LevelW-1:0] btn_i,
  input  logic [ElapsW-1:0] elapsed_i,
  output ctx_t              ctx_o,
  output logic              toggled_o
);

  logic [TimerW:0]   sum;
  logic [TimerW-1:0] timer_sat;
  logic [ClicksW-1:0] exp_ext;

  assign sum       = {1'b0, ctx_i.timer} + {{(TimerW+1-ElapsW){1'b0}}, elapsed_i};
  assign timer_sat = sum[TimerW] ? TimerMax : sum[TimerW-1:0];
  assign exp_ext   = {{(ClicksW-ExpW){1'b0}}, cfg_i.exp_clicks};

  always_comb begin
    ctx_o       = ctx_i;
    ctx_o.timer = timer_sat;
    toggled_o   = 1'b0;
    case (ctx_i.state)
      ST_OFF_IDLE: begin
        if (ign_i == LvlOn) begin
          ctx_o.clicks   = '0;
          ctx_o.last_btn = btn_i;
          ctx_o.state    = ST_COUNT;
          ctx_o.timer    = '0;
        end
      end
      ST_COUNT: begin
        if (timer_sat > cfg_i.timeout_ms || ctx_i.clicks > exp_ext) begin
          ctx_o.state = ST_ON_IDLE;
          ctx_o.timer = '0;
        end else if (ign_i == LvlOff) begin
          ctx_o.state = (ctx_i.clicks == exp_ext) ? ST_TOGGLE : ST_OFF_IDLE;
          ctx_o.timer = '0;
        end else begin
          if (ctx_i.last_btn == LvlOff && btn_i == LvlOn && ctx_i.clicks != ClicksMax) begin
            ctx_o.clicks = ctx_i.clicks + 1'b1;
          end
          ctx_o.last_btn = btn_i;
        end
      end
      ST_ON_IDLE: begin
        if (ign_i == LvlOff) begin
          ctx_o.state = ST_OFF_IDLE;
          ctx_o.timer = '0;
        end
      end
      ST_TOGGLE: begin
        ctx_o.enabled = ~ctx_i.enabled;
        toggled_o     = 1'b1;
        ctx_o.state   = ST_OFF_IDLE;
        ctx_o.timer   = '0;
      end
      default: begin
        ctx_o.state = ST_OFF_IDLE;
        ctx_o.timer = '0;
      end
    endcase
  end

endmodule

@@ sv/bsct_checker.sv @@
// Port-level checker for the button sequence toggle, bound to the top level.
module bsct_checker
  import bsct_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [InDataW-1:0]  s_axis_tdata_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // every accepted poll leaves a result behind
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted poll produced no result");

  // an empty output never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // a toggle always lands back in off idle
  a_toggle_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1] |-> m_axis_tdata_o[3:2] == ModeOffIdle)
    else $error("toggle reported outside off idle");

  // click count stays within one past the largest expected count
  a_clicks_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[8:4] <= 5'd16)
    else $error("click count out of range");

endmodule

bind button_sequence_config_toggle bsct_checker u_bsct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ sim/button_sequence_config_toggle_tb.sv @@
// Self-checking testbench for the button sequence configuration toggle.
module button_sequence_config_toggle_tb;
  import bsct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [LevelW-1:0] LvlUnknown = 2'd2;
  localparam logic [LevelW-1:0] LvlSpare   = 2'd3;
  localparam int unsigned       HoldCycles = 64;

  typedef struct packed {
    logic               enabled;
    logic               toggled;
    logic [1:0]         mode;
    logic [ClicksW-1:0] clicks;
  } status_t;

  typedef struct packed {
    logic [LevelW-1:0] ign;
    logic [LevelW-1:0] btn;
    logic [ElapsW-1:0] dt;
    logic              typed;
    status_t           want;
  } poll_t;

  logic                clk;
  logic                rst_n;
  logic                poll_valid;
  logic                poll_ready;
  logic [InDataW-1:0]  poll_data;
  logic                stat_valid;
  logic                stat_ready;
  logic [OutDataW-1:0] stat_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDatW-1:0]  cfg_data;

  // predictor state and its copy of the registers
  logic [1:0]         cur_mode;
  logic [ClicksW-1:0] press_count;
  logic [LevelW-1:0]  prev_btn;
  logic [TimerW-1:0]  mode_timer;
  logic               enabled_flag;
  logic [TimerW-1:0]  timeout_lim;
  logic [ExpW-1:0]    clicks_target;

  status_t     status_q [$];
  poll_t       directed [$];
  int unsigned mismatches = 0;
  int unsigned polls_sent = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;

  button_sequence_config_toggle dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (poll_valid),
    .s_axis_tready_o (poll_ready),
    .s_axis_tdata_i  (poll_data),
    .m_axis_tvalid_o (stat_valid),
    .m_axis_tready_i (stat_ready),
    .m_axis_tdata_o  (stat_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic status_t advance_status(input poll_t p);
    logic [TimerW:0] sum;
    status_t         s;
    sum = {1'b0, mode_timer} + {{(TimerW + 1 - ElapsW){1'b0}}, p.dt};
    mode_timer = sum[TimerW] ? TimerMax : sum[TimerW-1:0];
    s.toggled = 1'b0;
    case (cur_mode)
      ModeOffIdle: if (p.ign == LvlOn) begin
        press_count = '0;
        prev_btn    = p.btn;
        cur_mode    = ModeCount;
        mode_timer  = '0;
      end
      ModeCount: begin
        // timeout and overflow win over ignition off
        if (mode_timer > timeout_lim || press_count > {1'b0, clicks_target}) begin
          cur_mode   = ModeOnIdle;
          mode_timer = '0;
        end else if (p.ign == LvlOff) begin
          cur_mode   = (press_count == {1'b0, clicks_target}) ? ModeToggle : ModeOffIdle;
          mode_timer = '0;
        end else begin
          if (prev_btn == LvlOff && p.btn == LvlOn && press_count != ClicksMax)
            press_count = press_count + 1'b1;
          prev_btn = p.btn;
        end
      end
      ModeOnIdle: if (p.ign == LvlOff) begin
        cur_mode   = ModeOffIdle;
        mode_timer = '0;
      end
      default: begin
        enabled_flag = ~enabled_flag;
        s.toggled    = 1'b1;
        cur_mode     = ModeOffIdle;
        mode_timer   = '0;
      end
    endcase
    s.enabled = enabled_flag;
    s.mode    = cur_mode;
    s.clicks  = press_count;
    return s;
  endfunction

  function automatic poll_t row(input logic [LevelW-1:0] ign, input logic [LevelW-1:0] btn,
                                input logic [ElapsW-1:0] dt);
    poll_t p;
    p.ign   = ign;
    p.btn   = btn;
    p.dt    = dt;
    p.typed = 1'b0;
    p.want  = '0;
    return p;
  endfunction

  function automatic poll_t row_exp(input logic [LevelW-1:0] ign, input logic [LevelW-1:0] btn,
                                    input logic [ElapsW-1:0] dt, input logic en, input logic tg,
                                    input logic [1:0] md, input logic [ClicksW-1:0] cl);
    poll_t p;
    p = row(ign, btn, dt);
    p.typed        = 1'b1;
    p.want.enabled = en;
    p.want.toggled = tg;
    p.want.mode    = md;
    p.want.clicks  = cl;
    return p;
  endfunction

  function automatic logic [LevelW-1:0] rand_level();
    return LevelW'($urandom_range(0, 3));
  endfunction

  // mostly short steps so that sequences fit inside small timeouts
  function automatic logic [ElapsW-1:0] pace();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return '0;
    if (r < 9) return ElapsW'($urandom_range(1, 15));
    return ElapsW'($urandom_range(0, 255));
  endfunction

  // all tasks below start and end at a falling edge
  task automatic send_poll(input poll_t p);
    status_t want;
    if (burst_left == 0) begin
      if (!hold_req) begin
        poll_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
    end
    burst_left--;
    poll_data  = {4'b0, p.dt, p.btn, p.ign};
    poll_valid = 1'b1;
    do @(posedge clk); while (!poll_ready);
    want = advance_status(p);
    status_q.push_back(p.typed ? p.want : want);
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgTimeout:   timeout_lim = val;
      CfgExpClicks: clicks_target = val[ExpW-1:0];
      CfgInitEn:    enabled_flag = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    poll_valid = 1'b0;
    burst_left = 0;
    while (status_q.size() != 0) @(negedge clk);
  endtask

  task automatic press_run(input int unsigned n);
    repeat (n) begin
      send_poll(row(LvlOn, LvlOn, pace()));
      send_poll(row(LvlOn, ($urandom_range(0, 5) == 0) ? rand_level() : LvlOff, pace()));
    end
  endtask

  task automatic random_sequence();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      // well-formed: settle in off idle, switch on, press, switch off, one more poll
      repeat ($urandom_range(1, 3)) send_poll(row(LvlOff, rand_level(), pace()));
      n = ($urandom_range(0, 3) != 0) ? int'(clicks_target)
                                      : $urandom_range(0, int'(clicks_target) + 2);
      send_poll(row(LvlOn, LvlOff, pace()));
      press_run(n);
      send_poll(row(LvlOff, LvlOff, pace()));
      send_poll(row(LvlOff, rand_level(), pace()));
    end else if (kind <= 7) begin
      repeat ($urandom_range(1, 8))
        send_poll(row(rand_level(), rand_level(), ElapsW'($urandom_range(0, 255))));
    end else if (kind == 8) begin
      // linger in counting with long steps to run into the timeout
      send_poll(row(LvlOff, LvlOff, pace()));
      send_poll(row(LvlOn, rand_level(), pace()));
      repeat ($urandom_range(1, 12))
        send_poll(row(LvlOn, rand_level(), ElapsW'($urandom_range(0, 255))));
      send_poll(row(LvlOff, rand_level(), pace()));
      send_poll(row(LvlOff, LvlOff, pace()));
    end else begin
      // one or two presses too many
      send_poll(row(LvlOff, LvlOff, pace()));
      send_poll(row(LvlOn, LvlOff, pace()));
      press_run(int'(clicks_target) + $urandom_range(1, 2));
      repeat (2) send_poll(row(LvlOn, rand_level(), pace()));
      send_poll(row(LvlOff, LvlOff, pace()));
    end
  endtask

  task automatic run_phase(input logic [TimerW-1:0] tmo, input logic [ExpW-1:0] target,
                           input logic en, input int unsigned n, input int unsigned long_run,
                           input bit hold);
    int unsigned stop;
    drain();
    write_reg(CfgTimeout, tmo);
    write_reg(CfgExpClicks, CfgDatW'(target));
    write_reg(CfgInitEn, CfgDatW'(en));
    if (hold)
      hold_req = 1'b1;
    if (long_run != 0) begin
      // full-length steps drive the mode timer into saturation
      repeat (3) send_poll(row(LvlOff, LvlOff, 8'd0));
      send_poll(row(LvlOn, LvlOff, 8'd0));
      repeat (long_run) send_poll(row(LvlOn, LvlOff, 8'hFF));
      send_poll(row(LvlOff, LvlOff, 8'd0));
    end
    stop = polls_sent + n;
    while (polls_sent < stop)
      random_sequence();
  endtask

  initial begin : result_sink
    int unsigned span;
    int unsigned style;
    int unsigned tick;
    stat_ready = 1'b0;
    span  = 0;
    style = 0;
    tick  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stat_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(20, 200);
      end
      span--;
      tick++;
      case (style)
        0: stat_ready = 1'b1;
        1: stat_ready = 1'($urandom_range(0, 1));
        2: stat_ready = ($urandom_range(0, 3) == 0);
        default: stat_ready = (tick % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin : status_check
    status_t got;
    status_t want;
    if (rst_n && stat_valid && stat_ready) begin
      got.enabled = stat_data[0];
      got.toggled = stat_data[1];
      got.mode    = stat_data[3:2];
      got.clicks  = stat_data[8:4];
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected status transfer en=%0d tg=%0d mode=%0d clicks=%0d",
                   $realtime, got.enabled, got.toggled, got.mode, got.clicks);
      end else begin
        want = status_q.pop_front();
        if (got.enabled !== want.enabled || got.toggled !== want.toggled ||
            got.mode !== want.mode || got.clicks !== want.clicks) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: status expected en=%0d tg=%0d mode=%0d clicks=%0d, got %0d %0d %0d %0d",
                     $realtime, want.enabled, want.toggled, want.mode, want.clicks,
                     got.enabled, got.toggled, got.mode, got.clicks);
        end
      end
    end
  end

  initial begin : stimulus
    rst_n      = 1'b0;
    poll_valid = 1'b0;
    poll_data  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CfgTimeout;
    cfg_data   = '0;

    cur_mode       = ModeOffIdle;
    press_count    = '0;
    prev_btn       = LvlOff;
    mode_timer     = '0;
    timeout_lim    = TimeoutReset;
    clicks_target  = ExpClicksReset;
    enabled_flag   = InitEnReset;

    // reset defaults: six presses then ignition off arms the toggle
    //                    ign         btn         dt     en    tg    mode         clicks
    directed.push_back(row_exp(LvlOff,     LvlOff,     8'd0,   1'b1, 1'b0, ModeOffIdle, 5'd0));
    directed.push_back(row_exp(LvlUnknown, LvlSpare,   8'd255, 1'b1, 1'b0, ModeOffIdle, 5'd0));
    directed.push_back(row_exp(LvlSpare,   LvlUnknown, 8'd0,   1'b1, 1'b0, ModeOffIdle, 5'd0));
    directed.push_back(row_exp(LvlOn,      LvlOn,      8'd1,   1'b1, 1'b0, ModeCount,   5'd0));
    directed.push_back(row(LvlOn,      LvlOff,     8'd7));
    directed.push_back(row(LvlOn,      LvlOn,      8'd128));
    directed.push_back(row(LvlOn,      LvlUnknown, 8'd0));
    directed.push_back(row(LvlOn,      LvlOn,      8'd2));   // unknown before: no press
    directed.push_back(row(LvlOn,      LvlOff,     8'd0));
    directed.push_back(row(LvlOn,      LvlOn,      8'd3));
    directed.push_back(row(LvlOn,      LvlOff,     8'd0));
    directed.push_back(row(LvlOn,      LvlOn,      8'd64));
    directed.push_back(row(LvlOn,      LvlOff,     8'd0));
    directed.push_back(row(LvlOn,      LvlOn,      8'd5));
    directed.push_back(row(LvlOn,      LvlOff,     8'd0));
    directed.push_back(row(LvlOn,      LvlOn,      8'd9));
    directed.push_back(row(LvlOn,      LvlOff,     8'd0));
    directed.push_back(row(LvlOn,      LvlOn,      8'd17));
    directed.push_back(row(LvlUnknown, LvlSpare,   8'd4));   // neither on nor off
    directed.push_back(row_exp(LvlOff,     LvlOff,     8'd0,   1'b1, 1'b0, ModeToggle,  5'd6));
    directed.push_back(row_exp(LvlOff,     LvlOff,     8'd0,   1'b0, 1'b1, ModeOffIdle, 5'd6));
    directed.push_back(row_exp(LvlOn,      LvlOff,     8'd0,   1'b0, 1'b0, ModeCount,   5'd0));
    directed.push_back(row(LvlSpare,   LvlOn,      8'd200));
    directed.push_back(row_exp(LvlOff,     LvlOff,     8'd0,   1'b0, 1'b0, ModeOffIdle, 5'd1));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i])
      send_poll(directed[i]);

    run_phase(16'd400, 4'd2, 1'b0, 170, 0, 1'b1);
    run_phase(16'd0, 4'd0, 1'b1, 140, 0, 1'b0);
    run_phase(16'hFFFF, 4'd15, 1'b0, 60, 265, 1'b0);
    run_phase(16'hFFFE, 4'd1, 1'b1, 60, 262, 1'b0);
    repeat (2)
      run_phase(TimerW'($urandom_range(0, 3000)), ExpW'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)), 100, 0, 1'b0);

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
sv/bsct_pkg.sv
sv/bsct_cfg_regs.sv
sv/bsct_step.sv
sv/button_sequence_config_toggle.sv
sv/bsct_checker.sv
sim/button_sequence_config_toggle_tb.sv
